FILE: src/rx_fifo_xon_xoff_flow_macros.svh
// Assertion macros for the receive FIFO with XON/XOFF flow control.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef RX_FIFO_XON_XOFF_FLOW_MACROS_SVH
`define RX_FIFO_XON_XOFF_FLOW_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define RXF_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("rxf check failed: invariant");

// Antecedent at one edge implies consequent at the next edge.
`define RXF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rxf check failed: next-cycle property");

`endif

FILE: src/rxf_pkg.sv
// Shared types, codes and sizing constants of the receive FIFO block.
// No dependencies; every module of the block imports it.
package rxf_pkg;

  localparam int FIFO_DEPTH  = 8192;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
  localparam int MARK_W      = 14;
  localparam int FILL_W      = 14;
  localparam int IDLE_W      = 16;
  localparam int CMP_W       = (CNT_W > MARK_W) ? CNT_W : MARK_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_EOF  = 8'h1A;
  localparam logic [7:0] CH_XOFF = 8'h13;
  localparam logic [7:0] CH_XON  = 8'h11;

  localparam logic [MARK_W-1:0] DEF_HIGH = MARK_W'(6144);
  localparam logic [MARK_W-1:0] DEF_LOW  = MARK_W'(1024);

  // Input operation codes
  localparam logic [1:0] OP_RX   = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_STORED  = 3'd0;
  localparam logic [2:0] ST_CR      = 3'd1;
  localparam logic [2:0] ST_END     = 3'd2;
  localparam logic [2:0] ST_REFUSED = 3'd3;
  localparam logic [2:0] ST_NOT_RX  = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_FILTER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOW_EN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_MARK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_MARK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT  = 3'd4;

  typedef enum logic [2:0] {
    KIND_STORE,
    KIND_CR,
    KIND_EOF,
    KIND_POP,
    KIND_TICK,
    KIND_NOP
  } kind_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        rx_status;
    logic              out_valid;
    logic [7:0]        out_byte;
    logic              flow_send;
    logic [7:0]        flow_byte;
    logic              throttled_now;
    logic              input_ended;
    logic              finished;
    logic [FILL_W-1:0] fill_level;
  } out_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic              text_filter;
    logic              flow_enable;
    logic [MARK_W-1:0] high_mark;
    logic [MARK_W-1:0] low_mark;
    logic [IDLE_W-1:0] idle_limit;
  } cfg_t;

endpackage

FILE: src/rx_fifo_xon_xoff_flow.sv
// Top level of the serial receive FIFO with XON/XOFF watermark flow control.
// Depends on rxf_pkg, rxf_front, rxf_queue and rxf_back.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data): one transfer per item, an
//   operation (received byte, consumer pop, idle tick) and the received byte.
//   Result channel (out_valid / out_stall / out_data): exactly one result per
//   item, in order: receive status, popped byte, flow control byte to send,
//   throttle and end-of-input flags and the fill level after the item.
//   Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): always
//   ready; write only while no item is in flight.
// Path: each input transfer is written into the queue, and the command
//   executes from the queue head into the result register behind out_valid.
//   Throughput: one item per cycle while out_stall is low, as the back end
//   updates its pointers, fill count and watermark check for each command.
// Reset: pointers, fill count, throttle, end flag and idle timer clear; the
//   registers return to text mode off, flow off, marks 6144/1024, no timeout.
//   The byte store needs no clearing: only written entries are ever read.
// Stall: while out_stall holds a result, the back end halts, the two-entry
//   queue fills and in_stall rises; no item is dropped.
module rx_fifo_xon_xoff_flow (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rxf_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rxf_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rxf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rxf_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import rxf_pkg::*;

  cfg_t cfg_r;
  logic q_full, q_push, q_head_vld, q_pop;
  cmd_t q_push_cmd, q_head_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.text_filter <= 1'b0;
      cfg_r.flow_enable <= 1'b0;
      cfg_r.high_mark   <= DEF_HIGH;
      cfg_r.low_mark    <= DEF_LOW;
      cfg_r.idle_limit  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TEXT_FILTER: cfg_r.text_filter <= cfg_data[0];
        REG_FLOW_EN:     cfg_r.flow_enable <= cfg_data[0];
        REG_HIGH_MARK:   cfg_r.high_mark   <= cfg_data[MARK_W-1:0];
        REG_LOW_MARK:    cfg_r.low_mark    <= cfg_data[MARK_W-1:0];
        REG_IDLE_LIMIT:  cfg_r.idle_limit  <= cfg_data[IDLE_W-1:0];
        default: ;
      endcase
    end
  end

  rxf_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .push     (q_push),
    .push_cmd (q_push_cmd)
  );

  rxf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .head_vld (q_head_vld),
    .head_cmd (q_head_cmd),
    .pop      (q_pop)
  );

  rxf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head_vld  (q_head_vld),
    .head_cmd  (q_head_cmd),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: src/rxf_front.sv
// Front end: takes input transfers and classifies them into commands.
// Depends on rxf_pkg; feeds rxf_queue.
module rxf_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  rxf_pkg::in_item_t in_data,
  input  rxf_pkg::cfg_t     cfg,
  input  logic              q_full,
  output logic              push,
  output rxf_pkg::cmd_t     push_cmd
);
  import rxf_pkg::*;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // text handling is decided here so the back end sees a plain command
  always_comb begin
    push_cmd.data = in_data.rx_byte;
    unique case (in_data.operation)
      OP_RX: begin
        if (cfg.text_filter && in_data.rx_byte == CH_CR) begin
          push_cmd.kind = KIND_CR;
        end else if (cfg.text_filter && in_data.rx_byte == CH_EOF) begin
          push_cmd.kind = KIND_EOF;
        end else begin
          push_cmd.kind = KIND_STORE;
        end
      end
      OP_POP:  push_cmd.kind = KIND_POP;
      OP_TICK: push_cmd.kind = KIND_TICK;
      default: push_cmd.kind = KIND_NOP;
    endcase
  end

endmodule

FILE: src/rxf_queue.sv
// Short command queue between the front end and the back end.
// Depends on rxf_pkg; sits between rxf_front and rxf_back.
module rxf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rxf_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          head_vld,
  output rxf_pkg::cmd_t head_cmd,
  input  logic          pop
);
  import rxf_pkg::*;

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  localparam logic [QPTR_W-1:0] LAST = QPTR_W'(QUEUE_DEPTH - 1);

  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_vld = (count_r != '0);
  assign head_cmd = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: src/rxf_back.sv
// Back end: byte store, pointers, idle timer, watermark flow control and the
// result register. Depends on rxf_pkg and the assertion macro header.
`include "rx_fifo_xon_xoff_flow_macros.svh"

module rxf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  rxf_pkg::cfg_t      cfg,
  input  logic               head_vld,
  input  rxf_pkg::cmd_t      head_cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output rxf_pkg::out_item_t out_data
);
  import rxf_pkg::*;

  logic [7:0] mem [FIFO_DEPTH];
  logic [7:0] rd_data_r;

  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              held_r, held_nxt;
  logic              ended_r, ended_nxt;
  logic [IDLE_W-1:0] idle_r, idle_nxt;
  logic              res_vld_r;
  out_item_t         res_r, res_nxt;

  logic              exec;
  logic              do_write, do_read;
  logic              full, empty;
  logic [MARK_W-1:0] hi_mark, lo_mark;
  logic [2:0]        status;
  logic              fsend;
  logic [7:0]        fbyte;

  localparam logic [PTR_W-1:0] LAST = PTR_W'(FIFO_DEPTH - 1);

  // execute when the result slot is free or is being transferred out
  assign exec = head_vld && (!res_vld_r || !out_stall);
  assign pop  = exec;

  assign full    = (fill_r == CNT_W'(FIFO_DEPTH));
  assign empty   = (fill_r == '0);
  assign hi_mark = (cfg.high_mark == '0) ? DEF_HIGH : cfg.high_mark;
  assign lo_mark = (cfg.low_mark == '0) ? DEF_LOW : cfg.low_mark;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    ended_nxt  = ended_r;
    idle_nxt   = idle_r;
    held_nxt   = held_r;
    do_write   = 1'b0;
    do_read    = 1'b0;
    status     = ST_NOT_RX;
    fsend      = 1'b0;
    fbyte      = 8'h00;

    case (head_cmd.kind) inside
      KIND_STORE, KIND_CR, KIND_EOF: begin
        if (ended_r || full) begin
          status = ST_REFUSED;
        end else begin
          idle_nxt = '0;
          if (head_cmd.kind == KIND_CR) begin
            status = ST_CR;
          end else if (head_cmd.kind == KIND_EOF) begin
            status    = ST_END;
            ended_nxt = 1'b1;
          end else begin
            status     = ST_STORED;
            do_write   = 1'b1;
            wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
            fill_nxt   = fill_r + 1'b1;
          end
        end
      end
      KIND_POP: begin
        if (!empty) begin
          do_read    = 1'b1;
          rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
          fill_nxt   = fill_r - 1'b1;
        end
      end
      KIND_TICK: begin
        if (!ended_r && !full) begin
          if (idle_r != '1) begin
            idle_nxt = idle_r + 1'b1;
          end
          if (cfg.idle_limit != '0 && idle_nxt >= cfg.idle_limit) begin
            ended_nxt = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // watermarks with hysteresis on the level after this command
    if (cfg.flow_enable) begin
      if (!held_r && CMP_W'(fill_nxt) >= CMP_W'(hi_mark)) begin
        fsend    = 1'b1;
        fbyte    = CH_XOFF;
        held_nxt = 1'b1;
      end else if (held_r && CMP_W'(fill_nxt) <= CMP_W'(lo_mark)) begin
        fsend    = 1'b1;
        fbyte    = CH_XON;
        held_nxt = 1'b0;
      end
    end

    res_nxt.rx_status     = status;
    res_nxt.out_valid     = do_read;
    res_nxt.out_byte      = 8'h00;
    res_nxt.flow_send     = fsend;
    res_nxt.flow_byte     = fbyte;
    res_nxt.throttled_now = held_nxt;
    res_nxt.input_ended   = ended_nxt;
    res_nxt.finished      = ended_nxt && (fill_nxt == '0);
    res_nxt.fill_level    = FILL_W'(fill_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      fill_r    <= '0;
      held_r    <= 1'b0;
      ended_r   <= 1'b0;
      idle_r    <= '0;
      res_vld_r <= 1'b0;
    end else begin
      if (exec) begin
        wr_ptr_r <= wr_ptr_nxt;
        rd_ptr_r <= rd_ptr_nxt;
        fill_r   <= fill_nxt;
        held_r   <= held_nxt;
        ended_r  <= ended_nxt;
        idle_r   <= idle_nxt;
      end
      if (exec) begin
        res_vld_r <= 1'b1;
      end else if (!out_stall) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  // payload of the result register; read data lands in the same edge
  always_ff @(posedge clk) begin
    if (exec) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec && do_write) begin
      mem[wr_ptr_r] <= head_cmd.data;
    end
    if (exec && do_read) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  assign out_valid = res_vld_r;

  always_comb begin
    out_data          = res_r;
    out_data.out_byte = res_r.out_valid ? rd_data_r : 8'h00;
  end

  `RXF_ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_r <= CNT_W'(FIFO_DEPTH))
  `RXF_ASSERT_ALWAYS(a_empty_ptrs, clk, rst_n, (fill_r != '0) || (rd_ptr_r == wr_ptr_r))
  `RXF_ASSERT_NEXT(a_held_only_on_exec, clk, rst_n, !exec, $stable(held_r) && $stable(fill_r))
  `RXF_ASSERT_NEXT(a_ended_sticky, clk, rst_n, ended_r, ended_r)

endmodule

FILE: bench/rx_fifo_xon_xoff_flow_tb.sv
// Self-checking bench for the serial receive FIFO with XON/XOFF flow control.
// Needs rxf_pkg and the rx_fifo_xon_xoff_flow RTL. A shadow FIFO predicts
// every result, and random gaps and stalls are applied on both channels.
module rx_fifo_xon_xoff_flow_tb;
  import rxf_pkg::*;

  localparam logic [1:0] OP_NOP = 2'd3;

  // Shadow copy of the FIFO, the flow state and the registers
  class rx_fifo_shadow;
    cfg_t        regs;
    logic [7:0]  held_bytes[$];
    bit          throttled;
    bit          input_done;
    int unsigned idle_count;
    out_item_t   awaited_results[$];
    int          mismatches;
    int          result_no;

    function new();
      regs.text_filter = 1'b0;
      regs.flow_enable = 1'b0;
      regs.high_mark   = DEF_HIGH;
      regs.low_mark    = DEF_LOW;
      regs.idle_limit  = '0;
      throttled  = 1'b0;
      input_done = 1'b0;
      idle_count = 0;
      mismatches = 0;
      result_no  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TEXT_FILTER: regs.text_filter = data[0];
        REG_FLOW_EN:     regs.flow_enable = data[0];
        REG_HIGH_MARK:   regs.high_mark   = data[MARK_W-1:0];
        REG_LOW_MARK:    regs.low_mark    = data[MARK_W-1:0];
        REG_IDLE_LIMIT:  regs.idle_limit  = data[IDLE_W-1:0];
        default: ;
      endcase
    endfunction

    function bit tick_would_end();
      return regs.idle_limit != '0 && !input_done && held_bytes.size() < FIFO_DEPTH
             && idle_count + 1 >= 32'(regs.idle_limit);
    endfunction

    function void advance_fifo(in_item_t it);
      out_item_t   r;
      int unsigned hi_level;
      int unsigned lo_level;
      r = '0;
      r.rx_status = ST_NOT_RX;
      hi_level = 32'((regs.high_mark != '0) ? regs.high_mark : DEF_HIGH);
      lo_level = 32'((regs.low_mark != '0) ? regs.low_mark : DEF_LOW);
      case (it.operation)
        OP_RX: begin
          if (input_done || held_bytes.size() >= FIFO_DEPTH) begin
            r.rx_status = ST_REFUSED;
          end else begin
            idle_count = 0;
            if (regs.text_filter && it.rx_byte == CH_CR) begin
              r.rx_status = ST_CR;
            end else if (regs.text_filter && it.rx_byte == CH_EOF) begin
              input_done  = 1'b1;
              r.rx_status = ST_END;
            end else begin
              held_bytes.push_back(it.rx_byte);
              r.rx_status = ST_STORED;
            end
          end
        end
        OP_POP: begin
          if (held_bytes.size() > 0) begin
            r.out_valid = 1'b1;
            r.out_byte  = held_bytes.pop_front();
          end
        end
        OP_TICK: begin
          if (!input_done && held_bytes.size() < FIFO_DEPTH) begin
            if (idle_count < 65535) idle_count++;
            if (regs.idle_limit != '0 && idle_count >= 32'(regs.idle_limit))
              input_done = 1'b1;
          end
        end
        default: ;
      endcase
      // Hysteresis: XOFF on the way up, XON on the way down
      if (regs.flow_enable) begin
        if (!throttled && held_bytes.size() >= hi_level) begin
          r.flow_send = 1'b1;
          r.flow_byte = CH_XOFF;
          throttled   = 1'b1;
        end else if (throttled && held_bytes.size() <= lo_level) begin
          r.flow_send = 1'b1;
          r.flow_byte = CH_XON;
          throttled   = 1'b0;
        end
      end
      r.throttled_now = throttled;
      r.input_ended   = input_done;
      r.finished      = input_done && held_bytes.size() == 0;
      r.fill_level    = FILL_W'(held_bytes.size());
      awaited_results.push_back(r);
    endfunction

    function void check_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d %s: expected %0h, got %0h", result_no, field, want, got);
      end
    endfunction

    function void compare_result(out_item_t got);
      out_item_t want;
      result_no++;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing awaited: %h", result_no, got);
        return;
      end
      want = awaited_results.pop_front();
      check_field("rx_status", 16'(want.rx_status), 16'(got.rx_status));
      check_field("out_valid", 16'(want.out_valid), 16'(got.out_valid));
      check_field("out_byte", 16'(want.out_byte), 16'(got.out_byte));
      check_field("flow_send", 16'(want.flow_send), 16'(got.flow_send));
      check_field("flow_byte", 16'(want.flow_byte), 16'(got.flow_byte));
      check_field("throttled_now", 16'(want.throttled_now), 16'(got.throttled_now));
      check_field("input_ended", 16'(want.input_ended), 16'(got.input_ended));
      check_field("finished", 16'(want.finished), 16'(got.finished));
      check_field("fill_level", 16'(want.fill_level), 16'(got.fill_level));
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rx_fifo_shadow sb;

  int sent_count     = 0;
  bit send_quiet     = 1'b0;
  int stall_left     = 0;
  int rx_cycles      = 0;
  int results_seen   = 0;
  bit rx_quiet       = 1'b0;
  bit long_hold_done = 1'b0;

  rx_fifo_xon_xoff_flow dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("rx_fifo_xon_xoff_flow verification failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (send_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int pick_stall();
    int r;
    if (rx_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Receive side: check each transfer, stall at random, one long hold-off
  always @(posedge clk) begin
    rx_cycles++;
    if (rx_cycles % 256 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      sb.compare_result(out_data);
      results_seen++;
    end
    if (!long_hold_done && results_seen >= 500) begin
      long_hold_done = 1'b1;
      stall_left     = 400;
    end else if (stall_left == 0) begin
      stall_left = pick_stall();
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic in_item_t item_of(logic [1:0] operation, logic [7:0] data);
    in_item_t it;
    it.operation = operation;
    it.rx_byte   = data;
    return it;
  endfunction

  // Random item that keeps input open: avoid the end marker and the timeout
  function automatic in_item_t pick_item(bit fill_bias);
    in_item_t it;
    int       r;
    it.rx_byte = 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < (fill_bias ? 55 : 30)) it.operation = OP_RX;
    else if (r < 85) it.operation = OP_POP;
    else if (r < 96) it.operation = OP_TICK;
    else it.operation = OP_NOP;
    if (it.operation == OP_TICK && sb.tick_would_end()) it.operation = OP_RX;
    if (it.operation == OP_RX && sb.regs.text_filter) begin
      if ($urandom_range(0, 15) == 0) it.rx_byte = CH_CR;
      if (it.rx_byte == CH_EOF) it.rx_byte = CH_EOF ^ 8'h01;
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.advance_fifo(it);
    sent_count++;
    if (sent_count % 150 == 0) send_quiet = ($urandom_range(0, 3) == 0);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold input until every awaited result has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic text, input logic flow, input int high,
                            input int low, input int limit);
    logic [CFG_IDX_W-1:0]  idx [5];
    logic [CFG_DATA_W-1:0] vals [5];
    idx  = '{REG_TEXT_FILTER, REG_FLOW_EN, REG_HIGH_MARK, REG_LOW_MARK, REG_IDLE_LIMIT};
    vals = '{CFG_DATA_W'(text), CFG_DATA_W'(flow), CFG_DATA_W'(high),
             CFG_DATA_W'(low), CFG_DATA_W'(limit)};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(idx[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count);
    bit fill_bias;
    fill_bias = 1'b1;
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) fill_bias = 1'($urandom_range(0, 1));
      send_item(pick_item(fill_bias));
    end
  endtask

  initial begin
    int hi;
    sb = new();
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: text mode off, flow off, no timeout
    send_item(item_of(OP_POP, 8'h00));
    send_item(item_of(OP_NOP, 8'hFF));
    send_item(item_of(OP_TICK, 8'hA5));
    send_item(item_of(OP_RX, 8'h00));
    send_item(item_of(OP_RX, 8'hFF));
    send_item(item_of(OP_RX, CH_CR));
    send_item(item_of(OP_RX, CH_EOF));
    repeat (5) send_item(item_of(OP_POP, 8'h3C));
    settle();

    // Text mode, tight watermarks, short timeout kept from expiring
    set_config(1'b1, 1'b1, 3, 1, 3);
    send_item(item_of(OP_TICK, 8'h00));
    send_item(item_of(OP_TICK, 8'h00));
    send_item(item_of(OP_RX, CH_CR));
    send_item(item_of(OP_TICK, 8'h00));
    send_item(item_of(OP_TICK, 8'h00));
    send_item(item_of(OP_RX, 8'h55));
    send_item(item_of(OP_RX, 8'hAA));
    send_item(item_of(OP_RX, 8'h0F));
    send_item(item_of(OP_RX, 8'hF0));
    repeat (3) send_item(item_of(OP_POP, 8'h00));
    send_item(item_of(OP_TICK, 8'h00));
    send_item(item_of(OP_RX, 8'h01));
    send_item(item_of(OP_RX, 8'h02));
    settle();
    // Flow off while throttled: no XON, throttle holds
    set_config(1'b1, 1'b0, 3, 1, 3);
    repeat (3) send_item(item_of(OP_POP, 8'h00));
    settle();
    set_config(1'b1, 1'b1, 3, 1, 3);
    send_item(item_of(OP_NOP, 8'h00));
    settle();

    set_config(1'b1, 1'b1, 16, 4, 5);
    run_random(450);
    settle();
    set_config(1'b0, 1'b1, 1, 0, 0);
    run_random(200);
    settle();
    set_config(1'b1, 1'b0, 8, 8, 65535);
    run_random(150);
    settle();
    hi = $urandom_range(2, 40);
    set_config(1'($urandom_range(0, 1)), 1'b1, hi, $urandom_range(0, hi - 1),
               $urandom_range(2, 10));
    run_random(150);
    settle();

    // Partial fill with zero marks: the default watermarks apply
    set_config(1'b0, 1'b1, 0, 0, 0);
    while (sb.held_bytes.size() < 40) begin
      if ($urandom_range(0, 15) == 0) send_item(item_of(OP_TICK, 8'($urandom)));
      else send_item(item_of(OP_RX, 8'($urandom)));
    end
    send_item(item_of(OP_RX, 8'($urandom)));
    send_item(item_of(OP_TICK, 8'($urandom)));
    send_item(item_of(OP_NOP, 8'($urandom)));
    settle();
    // Marks at the very top of the range
    set_config(1'b1, 1'b1, FIFO_DEPTH, FIFO_DEPTH - 1, 65535);
    send_item(item_of(OP_RX, CH_CR));
    send_item(item_of(OP_POP, 8'h00));
    send_item(item_of(OP_RX, 8'hA5));
    send_item(item_of(OP_RX, 8'h5A));
    repeat (2) send_item(item_of(OP_POP, 8'h00));
    settle();
    set_config(1'b0, 1'b1, 0, 0, 0);
    while (sb.held_bytes.size() > 0) begin
      if ($urandom_range(0, 99) < 85) send_item(item_of(OP_POP, 8'($urandom)));
      else send_item(pick_item(1'b0));
    end
    send_item(item_of(OP_POP, 8'h00));
    settle();

    // Close the input once, either by end marker or by the idle timeout
    if ($urandom_range(0, 1) == 0) begin
      set_config(1'b1, 1'b1, 2, 0, 65535);
      send_item(item_of(OP_RX, 8'h41));
      send_item(item_of(OP_RX, 8'h42));
      send_item(item_of(OP_RX, CH_EOF));
      send_item(item_of(OP_RX, 8'h43));
      send_item(item_of(OP_RX, CH_CR));
      send_item(item_of(OP_TICK, 8'h00));
      repeat (3) send_item(item_of(OP_POP, 8'h00));
      send_item(item_of(OP_NOP, 8'h00));
    end else begin
      set_config(1'b0, 1'b0, 0, 0, 0);
      repeat (3) send_item(item_of(OP_RX, 8'($urandom)));
      repeat (30) send_item(item_of(OP_TICK, 8'($urandom)));
      settle();
      // Limit below the count already reached: the next tick ends input
      set_config(1'b0, 1'b1, 0, 0, 20);
      send_item(item_of(OP_TICK, 8'h00));
      send_item(item_of(OP_RX, 8'h77));
      send_item(item_of(OP_TICK, 8'h00));
      repeat (4) send_item(item_of(OP_POP, 8'h00));
    end
    in_valid <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (sb.mismatches == 0 && sb.awaited_results.size() == 0) begin
      $display("rx_fifo_xon_xoff_flow verification clean");
    end else begin
      $display("rx_fifo_xon_xoff_flow verification failed");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+src
src/rxf_pkg.sv
src/rxf_front.sv
src/rxf_queue.sv
src/rxf_back.sv
src/rx_fifo_xon_xoff_flow.sv
bench/rx_fifo_xon_xoff_flow_tb.sv
